@@ design/ptts_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the tick scheduler.
package ptts_pkg;

  localparam int MAX_TASKS_DEF   = 8;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int CMD_W  = 2;
  localparam int KIND_W = 2;
  localparam int ID_W   = 8;
  localparam int PRIO_W = 8;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic              add_wr;     // append input item to the table
    logic              resp_set;   // latch single-result response
    logic [KIND_W-1:0] resp_kind;
    logic              sort_init;  // i <= 0
    logic              rd_i;       // read entry i
    logic              hold_load;  // hold <= entry i, j <= i + 1
    logic              rd_j;       // read entry j
    logic              sort_cmp;   // compare hold with entry j, swap if needed, j++
    logic              sort_wb;    // write hold back to i, i++
    logic              tick_init;  // i <= 0, drop pending firing
    logic              tick_rd;    // read entry i
    logic              tick_eval;  // decrement, reload, report, i++
    logic              out_fin;    // push final tick result
    logic              out_resp;   // push latched response
  } ctrl_t;

  // datapath -> controller status
  typedef struct packed {
    logic sort_i_done;
    logic sort_j_done;
    logic tick_done;
    logic eval_stall;
    logic out_free;
  } stat_t;

endpackage

@@ design/ptts_ctrl.sv @@
// Sequencer for add, sort and tick walks of the scheduler table.
module ptts_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [ptts_pkg::CMD_W-1:0] s_tuser,
  input  ptts_pkg::stat_t            stat,
  output ptts_pkg::ctrl_t            ctrl
);

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b0000000001,
    ST_SORT_RDI  = 10'b0000000010,
    ST_SORT_LOAD = 10'b0000000100,
    ST_SORT_RDJ  = 10'b0000001000,
    ST_SORT_CMP  = 10'b0000010000,
    ST_SORT_WB   = 10'b0000100000,
    ST_TICK_RD   = 10'b0001000000,
    ST_TICK_EVAL = 10'b0010000000,
    ST_TICK_FIN  = 10'b0100000000,
    ST_RESP      = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (s_tuser)
            ptts_pkg::CMD_ADD: begin
              ctrl.add_wr    = 1'b1;
              ctrl.resp_set  = 1'b1;
              ctrl.resp_kind = ptts_pkg::KIND_ADD;
              state_next     = ST_RESP;
            end
            ptts_pkg::CMD_START: begin
              ctrl.resp_set  = 1'b1;
              ctrl.resp_kind = ptts_pkg::KIND_START;
              ctrl.sort_init = 1'b1;
              state_next     = ST_SORT_RDI;
            end
            ptts_pkg::CMD_TICK: begin
              ctrl.tick_init = 1'b1;
              state_next     = ST_TICK_RD;
            end
            default: begin
              state_next = ST_IDLE; // unused command: no result
            end
          endcase
        end
      end
      ST_SORT_RDI: begin
        if (stat.sort_i_done) begin
          state_next = ST_RESP;
        end else begin
          ctrl.rd_i  = 1'b1;
          state_next = ST_SORT_LOAD;
        end
      end
      ST_SORT_LOAD: begin
        ctrl.hold_load = 1'b1;
        state_next     = ST_SORT_RDJ;
      end
      ST_SORT_RDJ: begin
        if (stat.sort_j_done) begin
          state_next = ST_SORT_WB;
        end else begin
          ctrl.rd_j  = 1'b1;
          state_next = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        ctrl.sort_cmp = 1'b1;
        state_next    = ST_SORT_RDJ;
      end
      ST_SORT_WB: begin
        ctrl.sort_wb = 1'b1;
        state_next   = ST_SORT_RDI;
      end
      ST_TICK_RD: begin
        if (stat.tick_done) begin
          state_next = ST_TICK_FIN;
        end else begin
          ctrl.tick_rd = 1'b1;
          state_next   = ST_TICK_EVAL;
        end
      end
      ST_TICK_EVAL: begin
        if (!stat.eval_stall) begin
          ctrl.tick_eval = 1'b1;
          state_next     = ST_TICK_RD;
        end
      end
      ST_TICK_FIN: begin
        if (stat.out_free) begin
          ctrl.out_fin = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (stat.out_free) begin
          ctrl.out_resp = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/ptts_datapath.sv @@
// Task table memories, walk counters, sort hold register and result register.
module ptts_datapath #(
  parameter int MAX_TASKS   = ptts_pkg::MAX_TASKS_DEF,
  parameter int COUNT_WIDTH = ptts_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [47:0]                 s_tdata,
  input  ptts_pkg::ctrl_t             ctrl,
  output ptts_pkg::stat_t             stat,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,
  output logic [ptts_pkg::KIND_W-1:0] m_tuser,
  output logic                        m_tlast
);

  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int ID_W  = ptts_pkg::ID_W;
  localparam int PR_W  = ptts_pkg::PRIO_W;
  localparam int CW    = COUNT_WIDTH;

  // table storage, no reset: only occupied entries are read
  logic [ID_W-1:0] id_mem  [MAX_TASKS];
  logic [PR_W-1:0] pr_mem  [MAX_TASKS];
  logic [CW-1:0]   per_mem [MAX_TASKS];
  logic [CW-1:0]   cnt_mem [MAX_TASKS];

  logic [ID_W-1:0] rd_id;
  logic [PR_W-1:0] rd_pr;
  logic [CW-1:0]   rd_per;
  logic [CW-1:0]   rd_cnt;

  logic [ID_W-1:0] h_id;
  logic [PR_W-1:0] h_pr;
  logic [CW-1:0]   h_per;
  logic [CW-1:0]   h_cnt;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx_i;
  logic [CNT_W-1:0] idx_j;

  logic             pend_valid;
  logic [ID_W-1:0]  pend_id;

  logic                        out_valid;
  logic [ptts_pkg::KIND_W-1:0] out_kind;
  logic                        out_acc;
  logic                        out_fired;
  logic [ID_W-1:0]             out_id;
  logic                        out_last;

  logic [ptts_pkg::KIND_W-1:0] resp_kind;
  logic                        resp_acc;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ID_W-1:0]  wr_id;
  logic [PR_W-1:0]  wr_pr;
  logic [CW-1:0]    wr_per;
  logic [CW-1:0]    wr_cnt;

  logic             full;
  logic             swap;
  logic [CW-1:0]    cnt_dec;
  logic             fire;
  logic             out_free;
  logic             push;
  logic [ptts_pkg::KIND_W-1:0] push_kind;
  logic             push_acc;
  logic             push_fired;
  logic [ID_W-1:0]  push_id;
  logic             push_last;

  assign full     = (count >= CNT_W'(MAX_TASKS));
  assign swap     = (h_pr > rd_pr);
  assign cnt_dec  = rd_cnt - CW'(1);
  assign fire     = (cnt_dec == '0);
  assign out_free = !out_valid || m_tready;

  assign stat.sort_i_done = ({1'b0, idx_i} + (CNT_W + 1)'(1)) >= {1'b0, count};
  assign stat.sort_j_done = (idx_j >= count);
  assign stat.tick_done   = (idx_i >= count);
  assign stat.eval_stall  = fire && pend_valid && !out_free;
  assign stat.out_free    = out_free;

  // memory port selection
  always_comb begin
    rd_en   = ctrl.rd_i || ctrl.rd_j || ctrl.tick_rd;
    rd_addr = ctrl.rd_j ? idx_j[IDX_W-1:0] : idx_i[IDX_W-1:0];

    wr_en   = 1'b0;
    wr_addr = idx_i[IDX_W-1:0];
    wr_id   = h_id;
    wr_pr   = h_pr;
    wr_per  = h_per;
    wr_cnt  = h_cnt;
    if (ctrl.add_wr) begin
      wr_en   = !full;
      wr_addr = count[IDX_W-1:0];
      wr_id   = s_tdata[7:0];
      wr_per  = CW'(s_tdata[23:8]);
      wr_cnt  = CW'(s_tdata[39:24]);
      wr_pr   = s_tdata[47:40];
    end else if (ctrl.sort_cmp) begin
      // old holder of position i moves to j
      wr_en   = swap;
      wr_addr = idx_j[IDX_W-1:0];
    end else if (ctrl.sort_wb) begin
      wr_en   = 1'b1;
    end else if (ctrl.tick_eval) begin
      wr_en   = 1'b1;
      wr_id   = rd_id;
      wr_pr   = rd_pr;
      wr_per  = rd_per;
      wr_cnt  = fire ? rd_per : cnt_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_addr]  <= wr_id;
      pr_mem[wr_addr]  <= wr_pr;
      per_mem[wr_addr] <= wr_per;
      cnt_mem[wr_addr] <= wr_cnt;
    end
    if (rd_en) begin
      rd_id  <= id_mem[rd_addr];
      rd_pr  <= pr_mem[rd_addr];
      rd_per <= per_mem[rd_addr];
      rd_cnt <= cnt_mem[rd_addr];
    end
  end

  // sort hold register: current holder of position i
  always_ff @(posedge clk) begin
    if (ctrl.hold_load || (ctrl.sort_cmp && swap)) begin
      h_id  <= rd_id;
      h_pr  <= rd_pr;
      h_per <= rd_per;
      h_cnt <= rd_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.add_wr && !full) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sort_init || ctrl.tick_init) begin
      idx_i <= '0;
    end else if (ctrl.sort_wb || ctrl.tick_eval) begin
      idx_i <= idx_i + CNT_W'(1);
    end
    if (ctrl.hold_load) begin
      idx_j <= idx_i + CNT_W'(1);
    end else if (ctrl.sort_cmp) begin
      idx_j <= idx_j + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.resp_set) begin
      resp_kind <= ctrl.resp_kind;
      resp_acc  <= ctrl.add_wr && !full;
    end
  end

  // the newest firing is held back until we know whether it is the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (ctrl.tick_init || ctrl.out_fin) begin
      pend_valid <= 1'b0;
    end else if (ctrl.tick_eval && fire) begin
      pend_valid <= 1'b1;
    end
    if (ctrl.tick_eval && fire) begin
      pend_id <= rd_id;
    end
  end

  always_comb begin
    push       = 1'b0;
    push_kind  = ptts_pkg::KIND_TICK;
    push_acc   = 1'b0;
    push_fired = 1'b0;
    push_id    = '0;
    push_last  = 1'b1;
    if (ctrl.tick_eval && fire && pend_valid) begin
      push       = 1'b1;
      push_fired = 1'b1;
      push_id    = pend_id;
      push_last  = 1'b0;
    end else if (ctrl.out_fin) begin
      push       = 1'b1;
      push_fired = pend_valid;
      push_id    = pend_valid ? pend_id : '0;
    end else if (ctrl.out_resp) begin
      push       = 1'b1;
      push_kind  = resp_kind;
      push_acc   = resp_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (push) begin
      out_kind  <= push_kind;
      out_acc   <= push_acc;
      out_fired <= push_fired;
      out_id    <= push_id;
      out_last  <= push_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_id, out_fired, out_acc};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

endmodule

@@ design/periodic_task_tick_scheduler.sv @@
// Top level of the periodic task tick scheduler: controller plus datapath.
//
//  channel  dir  signals                      content (low bit up)
//  s        in   tvalid tready tdata tuser    tdata: task_id, period, first_delay,
//                                             priority_req; tuser: command
//  m        out  tvalid tready tdata tuser    tdata: accepted, fired, fired_task, 0;
//                tlast                        tuser: kind; tlast: last
//
// One item at a time; s_tready is high only while idle.
// Tick works through the n stored tasks over the one
// read port of the task table (read, then update, per entry).
// Start runs the exchange sort, walking the same port.
// A stalled m side holds the walk when a second firing needs the result register,
// and holds the final result of every item until that register frees up.
// rst is synchronous; it empties the table and drops any pending result.
module periodic_task_tick_scheduler #(
  parameter int MAX_TASKS   = ptts_pkg::MAX_TASKS_DEF,
  parameter int COUNT_WIDTH = ptts_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [47:0]                 s_tdata,  // task_id, period, first_delay, priority_req
  input  logic [ptts_pkg::CMD_W-1:0]  s_tuser,  // command
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,  // accepted, fired, fired_task, zero fill
  output logic [ptts_pkg::KIND_W-1:0] m_tuser,  // kind
  output logic                        m_tlast
);

  ptts_pkg::ctrl_t ctrl;
  ptts_pkg::stat_t stat;

  ptts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  ptts_datapath #(
    .MAX_TASKS   (MAX_TASKS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .ctrl     (ctrl),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
